// ----- rtl/sek_pkg.sv -----
// Shared constants, types and the exponential table for the squared exponential kernel.
package sek_pkg;

  localparam int MAX_DIMS        = 4;
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int NUM_SCALES      = 4;

  localparam int COORD_W    = 16;
  localparam int MAG_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int VAR_W      = 16;
  localparam int NUG_W      = 16;
  localparam int CNT_W      = 3;
  localparam int SUM_W      = 30;
  localparam int COV_W      = 25;
  localparam int ROM_W      = 16;
  localparam int SQ_SHIFT   = 8;
  localparam int COV_SHIFT  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ROM_IDX_W  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int LOOKUP_W   = SUM_W + ROM_IDX_W;

  localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(256);
  localparam logic [VAR_W-1:0]   VAR_RESET    = VAR_W'(256);
  localparam logic [NUG_W-1:0]   NUG_RESET    = '0;
  localparam logic [CNT_W-1:0]   CNT_RESET    = CNT_W'(1);
  localparam logic [SUM_W-1:0]   THR_RESET    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SCALE_0    = 3'd0,
    REG_INV_SCALE_1    = 3'd1,
    REG_INV_SCALE_2    = 3'd2,
    REG_INV_SCALE_3    = 3'd3,
    REG_VARIANCE       = 3'd4,
    REG_NUGGET_FACTOR  = 3'd5,
    REG_DIM_COUNT      = 3'd6,
    REG_ZERO_THRESHOLD = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic square;
    logic accum;
    logic lookup;
    logic interp;
    logic expv;
    logic mul_final;
    logic emit;
  } sek_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sek_sts_t;

  typedef logic [EXP_TABLE_DEPTH:0][ROM_W-1:0] exp_rom_t;

  // exp(-x), x in Q.31, result Q0.31: short series at x/1024, then square ten times
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    y    = x >> 10;
    term = 64'h8000_0000;
    e    = 64'h8000_0000;
    term = (term * y) >> 31;
    e    = e - term;
    term = ((term * y) >> 31) / 2;
    e    = e + term;
    term = ((term * y) >> 31) / 3;
    e    = e - term;
    term = ((term * y) >> 31) / 4;
    e    = e + term;
    term = ((term * y) >> 31) / 5;
    e    = e - term;
    for (int n = 0; n < 10; n++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    return e;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] x;
    logic [63:0] v;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      x = (64'(k) << 36) / EXP_TABLE_DEPTH;
      v = (exp_neg_q31(x) + (64'd1 << 14)) >> 15;
      rom[k] = (v > 64'd65535) ? {ROM_W{1'b1}} : v[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ----- rtl/sek_ctrl.sv -----
// Sequencing state machine for the squared exponential kernel.
module sek_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sek_pkg::sek_sts_t sts,
  output sek_pkg::sek_cmd_t cmd
);
  import sek_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCALE  = 9'b000000010,
    ST_SQUARE = 9'b000000100,
    ST_ACCUM  = 9'b000001000,
    ST_LOOKUP = 9'b000010000,
    ST_INTERP = 9'b000100000,
    ST_EXPV   = 9'b001000000,
    ST_FINAL  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = sts.last ? ST_LOOKUP : ST_IDLE;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_nxt  = ST_EXPV;
      end
      ST_EXPV: begin
        cmd.expv  = 1'b1;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.mul_final = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/sek_dp.sv -----
// Datapath of the squared exponential kernel: registers, shared multiplier, table, output stage.
module sek_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sek_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sek_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [sek_pkg::COORD_W-1:0]  in_first_coord,
  input  logic signed [sek_pkg::COORD_W-1:0]  in_second_coord,
  input  sek_pkg::sek_cmd_t                   cmd,
  output sek_pkg::sek_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sek_pkg::COV_W-1:0]           out_covariance,
  output logic                                out_at_origin
);
  import sek_pkg::*;

  logic [SCALE_W-1:0] inv_scale_r [NUM_SCALES];
  logic [VAR_W-1:0]   variance_r;
  logic [NUG_W-1:0]   nugget_r;
  logic [CNT_W-1:0]   dim_count_r;
  logic [SUM_W-1:0]   zero_thr_r;

  logic [DIM_W-1:0]   dim_r;
  logic [SUM_W-1:0]   sum_r;
  logic               origin_r;
  logic [MAG_W-1:0]   mag_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ROM_W-1:0]   hi_r;
  logic [ROM_W-1:0]   diff_r;
  logic [SUM_W-1:0]   frac_r;
  logic [ROM_W-1:0]   e_r;
  logic               out_valid_r;
  logic [COV_W-1:0]   out_covariance_r;
  logic               out_at_origin_r;

  logic signed [COORD_W:0] coord_diff;
  logic [COORD_W:0]        mag_full;
  logic [MAG_W-1:0]        mag_nxt;
  logic [CNT_W-1:0]        cnt_eff;
  logic [SCALE_W-1:0]      scale_sel;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [PROD_W-1:0]       prod_nxt;
  logic [NUG_W:0]          nug_op;
  logic [SUM_W-1:0]        sq_sat;
  logic [SUM_W:0]          sum_wide;
  logic [SUM_W-1:0]        sum_nxt;
  logic [LOOKUP_W-1:0]     lk;
  logic [ROM_IDX_W-1:0]    idx_raw;
  logic [ROM_IDX_W-1:0]    idx;
  logic [ROM_W-1:0]        rom_hi;
  logic [ROM_W-1:0]        rom_lo_raw;
  logic [ROM_W-1:0]        rom_lo;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SCALES; i++) begin
        inv_scale_r[i] <= SCALE_RESET;
      end
      variance_r  <= VAR_RESET;
      nugget_r    <= NUG_RESET;
      dim_count_r <= CNT_RESET;
      zero_thr_r  <= THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_INV_SCALE_0:    inv_scale_r[0] <= cfg_data[SCALE_W-1:0];
        REG_INV_SCALE_1:    inv_scale_r[1] <= cfg_data[SCALE_W-1:0];
        REG_INV_SCALE_2:    inv_scale_r[2] <= cfg_data[SCALE_W-1:0];
        REG_INV_SCALE_3:    inv_scale_r[3] <= cfg_data[SCALE_W-1:0];
        REG_VARIANCE:       variance_r     <= cfg_data[VAR_W-1:0];
        REG_NUGGET_FACTOR:  nugget_r       <= cfg_data[NUG_W-1:0];
        REG_DIM_COUNT:      dim_count_r    <= cfg_data[CNT_W-1:0];
        REG_ZERO_THRESHOLD: zero_thr_r     <= cfg_data[SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coord_diff = {in_first_coord[COORD_W-1], in_first_coord}
               - {in_second_coord[COORD_W-1], in_second_coord};
    mag_full   = coord_diff[COORD_W] ? (COORD_W+1)'(-coord_diff) : coord_diff;
    mag_nxt    = mag_full[MAG_W-1:0];

    if (dim_count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (dim_count_r > CNT_W'(MAX_DIMS)) begin
      cnt_eff = CNT_W'(MAX_DIMS);
    end else begin
      cnt_eff = dim_count_r;
    end
    sts.last     = (CNT_W'(dim_r) + CNT_W'(1)) >= cnt_eff;
    sts.out_free = !out_valid_r || !out_stall;

    scale_sel = inv_scale_r[dim_r];
    nug_op    = {1'b1, {NUG_W{1'b0}}} + (NUG_W+1)'(nugget_r);

    mul_a = '0;
    mul_b = '0;
    if (cmd.scale) begin
      mul_a = MUL_W'(mag_r);
      mul_b = MUL_W'(scale_sel);
    end else if (cmd.square) begin
      mul_a = prod_r[MUL_W-1:0];
      mul_b = prod_r[MUL_W-1:0];
    end else if (cmd.interp) begin
      mul_a = MUL_W'(frac_r);
      mul_b = MUL_W'(diff_r);
    end else if (cmd.mul_final) begin
      mul_a = MUL_W'(variance_r);
      mul_b = origin_r ? MUL_W'(nug_op) : MUL_W'(e_r);
    end
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

    sq_sat   = (|prod_r[PROD_W-1:SUM_W+SQ_SHIFT]) ? SUM_MAX
             : prod_r[SUM_W+SQ_SHIFT-1:SQ_SHIFT];
    sum_wide = {1'b0, sum_r} + {1'b0, sq_sat};
    sum_nxt  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    lk      = LOOKUP_W'(sum_r) * LOOKUP_W'(EXP_TABLE_DEPTH);
    idx_raw = lk[LOOKUP_W-1:SUM_W];
    idx     = (idx_raw >= ROM_IDX_W'(EXP_TABLE_DEPTH)) ? ROM_IDX_W'(EXP_TABLE_DEPTH - 1)
            : idx_raw;
    rom_hi     = EXP_ROM[idx];
    rom_lo_raw = EXP_ROM[ROM_IDX_W'(idx + 1'b1)];
    rom_lo     = (rom_lo_raw > rom_hi) ? rom_hi : rom_lo_raw;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r    <= '0;
      sum_r    <= '0;
      origin_r <= 1'b0;
    end else begin
      if (cmd.accum) begin
        sum_r    <= sum_nxt;
        origin_r <= (sum_nxt <= zero_thr_r);
        dim_r    <= sts.last ? '0 : DIM_W'(dim_r + 1'b1);
      end else if (cmd.emit) begin
        sum_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_nxt;
    end
    if (cmd.scale || cmd.square || cmd.interp || cmd.mul_final) begin
      prod_r <= prod_nxt;
    end
    if (cmd.lookup) begin
      hi_r   <= rom_hi;
      diff_r <= rom_hi - rom_lo;
      frac_r <= lk[SUM_W-1:0];
    end
    if (cmd.expv) begin
      e_r <= hi_r - prod_r[SUM_W+ROM_W-1:SUM_W];
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_covariance_r <= prod_r[COV_W+COV_SHIFT-1:COV_SHIFT];
      out_at_origin_r  <= origin_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_covariance = out_covariance_r;
  assign out_at_origin  = out_at_origin_r;

endmodule

// ----- rtl/squared_exponential_kernel.sv -----
// Top level of the squared exponential covariance kernel.
//
// Each input request carries one coordinate of each of two points (signed Q8.8).
// Requests for dimensions 0 .. dimension_count-1 of a point pair arrive in order;
// the last one produces one output request: covariance (Q9.16) and at_origin.
// A request is taken when in_valid is high and in_stall is low, likewise on out_.
// The block works on one request at a time through a single shared multiplier:
// a request that does not end a point pair passes the scale, square and
// accumulate states; the one that ends it goes on through lookup, interpolate,
// exponent and final multiply to emit, which waits for a free output register.
// A stalled receiver thus holds only the last request of the following pair,
// never the earlier dimensions. Registers are written via cfg_wr_en/cfg_index/
// cfg_data; the user must do so only while idle, the block does not enforce it.
// Synchronous active-low reset restores the register defaults, clears the
// distance sum and the dimension counter, and drops out_valid.
module squared_exponential_kernel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sek_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sek_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sek_pkg::COORD_W-1:0]  in_first_coord,
  input  logic signed [sek_pkg::COORD_W-1:0]  in_second_coord,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sek_pkg::COV_W-1:0]           out_covariance,
  output logic                                out_at_origin
);
  import sek_pkg::*;

  sek_cmd_t cmd;
  sek_sts_t sts;

  sek_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sek_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_first_coord  (in_first_coord),
    .in_second_coord (in_second_coord),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_covariance  (out_covariance),
    .out_at_origin   (out_at_origin)
  );

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in progress");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  a_load_then_scale: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.scale)
    else $error("scale step did not follow load");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

// ----- sim/squared_exponential_kernel_checker.sv -----
`timescale 1ns / 1ps
// Checker for the squared exponential kernel: tracks registers, predicts covariance, compares.
module squared_exponential_kernel_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sek_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sek_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [sek_pkg::COORD_W-1:0]  in_first_coord,
  input  logic signed [sek_pkg::COORD_W-1:0]  in_second_coord,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [sek_pkg::COV_W-1:0]           out_covariance,
  input  logic                                out_at_origin,
  output int                                  fail_count,
  output int                                  open_count,
  output int                                  result_count,
  output int                                  origin_count
);
  import sek_pkg::*;

  typedef struct packed {
    logic [COV_W-1:0] cov;
    logic             origin;
  } cov_result_t;

  cov_result_t        awaiting_q[$];
  logic [ROM_W-1:0]   decay_lut [0:EXP_TABLE_DEPTH];

  logic [SCALE_W-1:0] scale_r [NUM_SCALES];
  logic [VAR_W-1:0]   amp_r;
  logic [NUG_W-1:0]   nug_r;
  logic [CNT_W-1:0]   ndims_r;
  logic [SUM_W-1:0]   thresh_r;
  logic [DIM_W-1:0]   dim_pos;
  logic [SUM_W-1:0]   sq_dist_acc;

  function automatic logic [63:0] decay_q31(input logic [63:0] arg);
    logic [63:0] step_v;
    logic [63:0] term_v;
    logic [63:0] acc;
    step_v = arg >> 10;
    term_v = 64'h8000_0000;
    acc    = 64'h8000_0000;
    for (int n = 1; n <= 5; n++) begin
      term_v = ((term_v * step_v) >> 31) / 64'(n);
      if (n % 2 == 1) acc = acc - term_v;
      else acc = acc + term_v;
    end
    for (int n = 0; n < 10; n++) begin
      acc = (acc * acc + 64'h4000_0000) >> 31;
    end
    return acc;
  endfunction

  initial begin
    logic [63:0] arg;
    logic [63:0] v;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      arg = (64'(k) << 36) / 64'(EXP_TABLE_DEPTH);
      v   = (decay_q31(arg) + 64'h4000) >> 15;
      decay_lut[k] = (v > 64'd65535) ? 16'hFFFF : v[ROM_W-1:0];
    end
  end

  function automatic logic [ROM_W-1:0] lut_lookup(input logic [SUM_W-1:0] s);
    logic [63:0]      pos;
    logic [63:0]      frac;
    int unsigned      slot;
    logic [ROM_W-1:0] hi;
    logic [ROM_W-1:0] lo;
    pos  = 64'(s) * 64'(EXP_TABLE_DEPTH);
    slot = 32'(pos >> 30);
    frac = pos & 64'(SUM_MAX);
    if (slot >= EXP_TABLE_DEPTH) slot = EXP_TABLE_DEPTH - 1;
    hi = decay_lut[slot];
    lo = decay_lut[slot + 1];
    if (lo > hi) lo = hi;
    return hi - ROM_W'((64'(hi - lo) * frac) >> 30);
  endfunction

  function automatic bit fold_coordinate(input logic signed [COORD_W-1:0] a,
                                         input logic signed [COORD_W-1:0] b,
                                         output cov_result_t res);
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [63:0]             scaled;
    logic [63:0]             sq;
    logic [63:0]             acc;
    logic [63:0]             prod;
    int                      span;
    res  = '0;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag  = diff[COORD_W] ? -diff : diff;
    scaled = 64'(mag) * 64'(scale_r[dim_pos]);
    sq = (scaled * scaled) >> SQ_SHIFT;
    if (sq > 64'(SUM_MAX)) sq = 64'(SUM_MAX);
    acc = 64'(sq_dist_acc) + sq;
    if (acc > 64'(SUM_MAX)) acc = 64'(SUM_MAX);
    sq_dist_acc = acc[SUM_W-1:0];
    span = int'(ndims_r);
    if (span < 1) span = 1;
    if (span > MAX_DIMS) span = MAX_DIMS;
    if (int'(dim_pos) + 1 < span) begin
      dim_pos = dim_pos + 1'b1;
      return 1'b0;
    end
    if (sq_dist_acc <= thresh_r) begin
      prod = 64'(amp_r) * (64'd65536 + 64'(nug_r));
      res.origin = 1'b1;
    end else begin
      prod = 64'(amp_r) * 64'(lut_lookup(sq_dist_acc));
      res.origin = 1'b0;
    end
    res.cov = COV_W'(prod >> COV_SHIFT);
    dim_pos = '0;
    sq_dist_acc = '0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input cov_result_t got,
                               input cov_result_t want);
    fail_count++;
    $display("[%0t] mismatch on %s: got cov=%0d origin=%0d, predicted cov=%0d origin=%0d",
             $realtime, what, got.cov, got.origin, want.cov, want.origin);
  endtask

  always @(posedge clk) begin
    cov_result_t got;
    cov_result_t want;
    cov_result_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SCALES; i++) scale_r[i] = SCALE_RESET;
      amp_r       = VAR_RESET;
      nug_r       = NUG_RESET;
      ndims_r     = CNT_RESET;
      thresh_r    = THR_RESET;
      dim_pos     = '0;
      sq_dist_acc = '0;
      awaiting_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_INV_SCALE_0:    scale_r[0] = cfg_data[SCALE_W-1:0];
          REG_INV_SCALE_1:    scale_r[1] = cfg_data[SCALE_W-1:0];
          REG_INV_SCALE_2:    scale_r[2] = cfg_data[SCALE_W-1:0];
          REG_INV_SCALE_3:    scale_r[3] = cfg_data[SCALE_W-1:0];
          REG_VARIANCE:       amp_r      = cfg_data[VAR_W-1:0];
          REG_NUGGET_FACTOR:  nug_r      = cfg_data[NUG_W-1:0];
          REG_DIM_COUNT:      ndims_r    = cfg_data[CNT_W-1:0];
          REG_ZERO_THRESHOLD: thresh_r   = cfg_data[SUM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.cov    = out_covariance;
        got.origin = out_at_origin;
        if (awaiting_q.size() == 0) begin
          flag_mismatch("unrequested result", got, '0);
        end else begin
          want = awaiting_q.pop_front();
          result_count++;
          if (want.origin) origin_count++;
          if (got.cov !== want.cov) flag_mismatch("covariance", got, want);
          if (got.origin !== want.origin) flag_mismatch("at_origin", got, want);
        end
      end
      if (in_valid && !in_stall) begin
        if (fold_coordinate(in_first_coord, in_second_coord, fresh)) awaiting_q.push_back(fresh);
      end
    end
    open_count = awaiting_q.size();
  end

endmodule

// ----- sim/squared_exponential_kernel_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the squared exponential kernel: clock, reset, stimulus and verdict.
module squared_exponential_kernel_tb;
  import sek_pkg::*;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 8;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [COORD_W-1:0]  in_first_coord;
  logic signed [COORD_W-1:0]  in_second_coord;
  logic                       out_valid;
  logic                       out_stall;
  logic [COV_W-1:0]           out_covariance;
  logic                       out_at_origin;

  int fail_count;
  int open_count;
  int result_count;
  int origin_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int settings_used;

  squared_exponential_kernel dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_coord  (in_first_coord),
    .in_second_coord (in_second_coord),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_covariance  (out_covariance),
    .out_at_origin   (out_at_origin)
  );

  squared_exponential_kernel_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_coord  (in_first_coord),
    .in_second_coord (in_second_coord),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_covariance  (out_covariance),
    .out_at_origin   (out_at_origin),
    .fail_count      (fail_count),
    .open_count      (open_count),
    .result_count    (result_count),
    .origin_count    (origin_count)
  );

  always begin
    clk = 1'b0;
    #4 clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_request(input logic signed [COORD_W-1:0] a,
                              input logic signed [COORD_W-1:0] b);
    bit took;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_first_coord  <= a;
    in_second_coord <= b;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    requests_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (open_count == 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] s0, input logic [15:0] s1,
                              input logic [15:0] s2, input logic [15:0] s3,
                              input logic [15:0] amp, input logic [15:0] nug,
                              input logic [2:0] ndims, input logic [SUM_W-1:0] thr);
    reg_write(REG_INV_SCALE_0, {14'($urandom), s0});
    reg_write(REG_INV_SCALE_1, {14'($urandom), s1});
    reg_write(REG_INV_SCALE_2, {14'($urandom), s2});
    reg_write(REG_INV_SCALE_3, {14'($urandom), s3});
    reg_write(REG_VARIANCE, {14'($urandom), amp});
    reg_write(REG_NUGGET_FACTOR, {14'($urandom), nug});
    reg_write(REG_DIM_COUNT, {27'($urandom), ndims});
    reg_write(REG_ZERO_THRESHOLD, thr);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 4096));
      default: return 16'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] pick_threshold();
    case ($urandom_range(7))
      0: return '0;
      1: return SUM_MAX;
      2: return SUM_W'($urandom);
      default: return SUM_W'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic pick_coords(output logic signed [15:0] a, output logic signed [15:0] b);
    int delta;
    int t;
    b = 16'($urandom);
    case ($urandom_range(9))
      0: a = b;
      1, 2, 3, 4, 5: begin
        delta = int'($urandom_range(0, 1024)) - 512;
        t = int'(b) + delta;
        if (t > 32767 || t < -32768) t = int'(b) - delta;
        a = 16'(t);
      end
      6, 7, 8: a = 16'($urandom);
      default: begin
        a = pick_extreme();
        b = pick_extreme();
      end
    endcase
  endtask

  initial begin
    logic signed [15:0] a;
    logic signed [15:0] b;
    int                 n_items;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_first_coord  = '0;
    in_second_coord = '0;
    send_idle_pct   = 17;
    recv_idle_pct   = 65;
    requests_sent   = 0;
    settings_used   = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(0, 0);
    send_request(32767, -32768);
    send_request(-32768, 32767);
    send_request(256, 0);
    send_request(-1, 0);
    send_request(32767, 32767);
    settle();

    program_regs(16'hFFFF, 16'd0, 16'd1, 16'd300, 16'hFFFF, 16'hFFFF, 3'd7, '0);
    send_request(1, 0);
    send_request(32767, -32768);
    send_request(5, -5);
    send_request(100, 0);
    send_request(0, 0);
    send_request(123, -4000);
    send_request(-77, -77);
    send_request(9, 9);
    send_request(10, 0);
    send_request(0, 10);
    settle();

    program_regs(16'd256, 16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 3'd2, SUM_MAX);
    send_request(7, -7);
    send_request(-32768, 32767);
    send_request(0, 0);
    settle();

    program_regs(16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'd1, 3'd0, 30'd256);
    send_request(0, 1);
    send_request(0, 2);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 65;
      end else if (p < 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0)
        program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 3'd1, '0);
      else if (p == 1)
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd4,
                     SUM_MAX);
      else
        program_regs(pick_scale(), pick_scale(), pick_scale(), pick_scale(),
                     16'($urandom), 16'($urandom), 3'($urandom), pick_threshold());
      n_items = $urandom_range(100, 125);
      for (int i = 0; i < n_items; i++) begin
        pick_coords(a, b);
        send_request(a, b);
      end
      settle();
    end

    $display("Run drove %0d coordinate requests across %0d register settings.",
             requests_sent, settings_used);
    $display("Checked %0d covariance results, %0d of them from the zero-distance branch.",
             result_count, origin_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
